### sv/tgsa_pkg.sv
`default_nettype none
package tgsa_pkg;

	// fixed geometry of one request
	localparam int NUM_DIRS = 4;
	localparam int DIR_W    = 2;
	localparam int DENS_W   = 16;
	localparam int GREEN_W  = 8;
	localparam int MIN_W    = 6;
	localparam int SUM_W    = 18;
	localparam int REM_W    = 8;
	localparam int NUM_W    = 26;
	localparam int QUO_W    = 8;
	localparam int BIT_W    = 3;
	localparam int CUR_W    = 10;

	// register map (index = paddr[3:2])
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_CYC_TARGET = 2'd0;
	localparam logic [1:0] REG_GRN_FLOOR  = 2'd1;
	localparam logic [1:0] REG_GRN_CAP    = 2'd2;

	// register reset values
	localparam logic [GREEN_W-1:0] CYC_TARGET_RST = 8'd30;
	localparam logic [MIN_W-1:0]   GRN_FLOOR_RST  = 6'd5;
	localparam logic [GREEN_W-1:0] GRN_CAP_RST    = 8'd60;

	typedef logic [DENS_W-1:0]  dens_t;
	typedef logic [GREEN_W-1:0] green_t;

	typedef struct packed {
		dens_t dens_north;
		dens_t dens_east;
		dens_t dens_south;
		dens_t dens_west;
	} in_item_t;

	typedef struct packed {
		green_t green_north;
		green_t green_east;
		green_t green_south;
		green_t green_west;
	} out_item_t;

	typedef struct packed {
		logic [GREEN_W-1:0] cyc_target;
		logic [MIN_W-1:0]   grn_floor;
		logic [GREEN_W-1:0] grn_cap;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic             mul;
		logic             div;
		logic             store;
		logic             add;
		logic             sub;
		logic [DIR_W-1:0] dir;
		logic [BIT_W-1:0] bit_idx;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sum_zero;
		logic add_go;
		logic sub_go;
	} dp_status_t;

endpackage
`default_nettype wire

### sv/traffic_green_split_allocator.sv
// Proportional green-split allocator.
// Input channel (in_valid/in_stall/in_data) carries four approach densities;
// output channel (out_valid/out_stall/out_data) returns four green times.
// A request is taken when valid is high and stall is low at a clock edge.
// Registers for the cycle target, the minimum green and the maximum green
// sit on the APB port at byte addresses 0, 4 and 8; pready is always high.
// One request is worked at a time: in_stall stays high from acceptance
// until its result is loaded into the output register.
// When all densities are zero the result is loaded without working any shares;
// otherwise the four shares are worked out (one multiply, eight restoring divide
// steps and one store per direction), the budget is adjusted one second at a
// time, and the two adjustment loops are closed before the result is loaded.
// The next request can be taken in the cycle after a load, so a new request
// is never taken before the last result is loaded.
// While out_stall is high the result is held; the next request can be
// accepted and worked, and waits for the output register to free up.
// Reset (arst_n low) clears the sequencer and output valid and restores
// the register defaults 30, 5 and 60.
`default_nettype none
module traffic_green_split_allocator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire tgsa_pkg::in_item_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output tgsa_pkg::out_item_t                  out_data,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tgsa_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	tgsa_pkg::cfg_t       cfg_q;
	tgsa_pkg::dp_cmd_t    cmd;
	tgsa_pkg::dp_status_t status;
	tgsa_pkg::out_item_t  result;
	tgsa_pkg::out_item_t  out_q;
	logic                 out_valid_q;
	logic                 busy;
	logic                 out_load;
	logic                 out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cyc_target <= tgsa_pkg::CYC_TARGET_RST;
			cfg_q.grn_floor  <= tgsa_pkg::GRN_FLOOR_RST;
			cfg_q.grn_cap    <= tgsa_pkg::GRN_CAP_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				tgsa_pkg::REG_CYC_TARGET: cfg_q.cyc_target <= pwdata[7:0];
				tgsa_pkg::REG_GRN_FLOOR:  cfg_q.grn_floor  <= pwdata[5:0];
				tgsa_pkg::REG_GRN_CAP:    cfg_q.grn_cap    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			tgsa_pkg::REG_CYC_TARGET: prdata = 32'(cfg_q.cyc_target);
			tgsa_pkg::REG_GRN_FLOOR:  prdata = 32'(cfg_q.grn_floor);
			tgsa_pkg::REG_GRN_CAP:    prdata = 32'(cfg_q.grn_cap);
			default:                  prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	tgsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.out_load (out_load)
	);

	tgsa_dp u_dp (
		.clk     (clk),
		.cfg     (cfg_q),
		.in_data (in_data),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

	assign in_stall = busy;
	assign out_free = !out_valid_q || !out_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### sv/tgsa_ctrl.sv
`default_nettype none
module tgsa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               out_free,
	input  wire tgsa_pkg::dp_status_t status,
	output tgsa_pkg::dp_cmd_t       cmd,
	output logic                    busy,
	output logic                    out_load
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_STORE = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;
	localparam logic [2:0] ST_SUB   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [tgsa_pkg::DIR_W-1:0] dir_q, dir_d;
	logic [tgsa_pkg::BIT_W-1:0] bit_q, bit_d;

	// next state and command decode
	always_comb begin
		state_d     = state_q;
		dir_d       = dir_q;
		bit_d       = bit_q;
		cmd         = '0;
		cmd.dir     = dir_q;
		cmd.bit_idx = bit_q;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					dir_d    = '0;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				if (status.sum_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.mul = 1'b1;
					bit_d   = '1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				bit_d   = bit_q - tgsa_pkg::BIT_W'(1);
				if (bit_q == '0) state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				dir_d     = dir_q + tgsa_pkg::DIR_W'(1);
				if (dir_q == tgsa_pkg::DIR_W'(tgsa_pkg::NUM_DIRS - 1)) state_d = ST_ADD;
				else state_d = ST_MUL;
			end
			ST_ADD: begin
				if (status.add_go) cmd.add = 1'b1;
				else state_d = ST_SUB;
			end
			ST_SUB: begin
				if (status.sub_go) cmd.sub = 1'b1;
				else state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dir_q   <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			dir_q   <= dir_d;
			bit_q   <= bit_d;
		end
	end

endmodule
`default_nettype wire

### sv/tgsa_dp.sv
`default_nettype none
module tgsa_dp (
	input  wire logic               clk,
	input  wire tgsa_pkg::cfg_t     cfg,
	input  wire tgsa_pkg::in_item_t in_data,
	input  wire tgsa_pkg::dp_cmd_t  cmd,
	output tgsa_pkg::dp_status_t    status,
	output tgsa_pkg::out_item_t     result
);

	localparam int N = tgsa_pkg::NUM_DIRS;

	tgsa_pkg::dens_t  dens_q  [N];
	tgsa_pkg::green_t green_q [N];
	tgsa_pkg::dens_t  dens_in [N];
	logic [tgsa_pkg::SUM_W-1:0]   sum_q, sum_in;
	logic [tgsa_pkg::REM_W-1:0]   rem_q;
	logic [tgsa_pkg::GREEN_W-1:0] budget_q, floor_sum, budget_in;
	logic [tgsa_pkg::CUR_W-1:0]   current_q;
	logic [tgsa_pkg::NUM_W-1:0]   num_q, trial;
	logic [tgsa_pkg::QUO_W-1:0]   quo_q;
	logic [23:0]                  product;
	logic [tgsa_pkg::GREEN_W:0]   g_wide;
	tgsa_pkg::green_t             g_cap;
	logic [tgsa_pkg::DIR_W-1:0]   hi_idx, lo_idx;
	logic                         hi_found, lo_found;

	assign dens_in[0] = in_data.dens_north;
	assign dens_in[1] = in_data.dens_east;
	assign dens_in[2] = in_data.dens_south;
	assign dens_in[3] = in_data.dens_west;

	// sum of densities and budget for a new request
	assign sum_in = tgsa_pkg::SUM_W'(dens_in[0]) + tgsa_pkg::SUM_W'(dens_in[1])
		+ tgsa_pkg::SUM_W'(dens_in[2]) + tgsa_pkg::SUM_W'(dens_in[3]);
	assign floor_sum = tgsa_pkg::GREEN_W'({2'b00, cfg.grn_floor} * 8'(N));
	assign budget_in = (cfg.cyc_target > floor_sum) ? cfg.cyc_target : floor_sum;

	// scaled density; the rounding term is added when num_q is loaded
	assign product = 24'(dens_q[cmd.dir]) * 24'(rem_q);

	// restoring divide by 2*sum, one quotient bit a cycle
	assign trial = tgsa_pkg::NUM_W'({sum_q, 1'b0}) << cmd.bit_idx;

	// first pass green with cap
	assign g_wide = {3'b000, cfg.grn_floor} + {1'b0, quo_q};
	assign g_cap  = (g_wide > {1'b0, cfg.grn_cap}) ? cfg.grn_cap : g_wide[7:0];

	// densest direction below max, sparsest above min, lower index wins ties
	always_comb begin
		hi_idx   = '0;
		lo_idx   = '0;
		hi_found = 1'b0;
		lo_found = 1'b0;
		for (int i = 0; i < N; i++) begin
			if (green_q[i] < cfg.grn_cap && (!hi_found || dens_q[i] > dens_q[hi_idx])) begin
				hi_idx   = tgsa_pkg::DIR_W'(i);
				hi_found = 1'b1;
			end
			if (green_q[i] > {2'b00, cfg.grn_floor}
				&& (!lo_found || dens_q[i] < dens_q[lo_idx])) begin
				lo_idx   = tgsa_pkg::DIR_W'(i);
				lo_found = 1'b1;
			end
		end
	end

	assign status.sum_zero = (sum_q == '0);
	assign status.add_go   = hi_found && (current_q < tgsa_pkg::CUR_W'(budget_q));
	assign status.sub_go   = lo_found && (current_q > tgsa_pkg::CUR_W'(budget_q));

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < N; i++) begin
				dens_q[i]  <= dens_in[i];
				green_q[i] <= {2'b00, cfg.grn_floor};
			end
			sum_q     <= sum_in;
			budget_q  <= budget_in;
			rem_q     <= budget_in - floor_sum;
			current_q <= '0;
		end
		if (cmd.mul) begin
			num_q <= tgsa_pkg::NUM_W'({product, 1'b0}) + tgsa_pkg::NUM_W'(sum_q);
			quo_q <= '0;
		end
		if (cmd.div && num_q >= trial) begin
			num_q              <= num_q - trial;
			quo_q[cmd.bit_idx] <= 1'b1;
		end
		if (cmd.store) begin
			green_q[cmd.dir] <= g_cap;
			current_q        <= current_q + tgsa_pkg::CUR_W'(g_cap);
		end
		if (cmd.add) begin
			green_q[hi_idx] <= green_q[hi_idx] + tgsa_pkg::GREEN_W'(1);
			current_q       <= current_q + tgsa_pkg::CUR_W'(1);
		end
		if (cmd.sub) begin
			green_q[lo_idx] <= green_q[lo_idx] - tgsa_pkg::GREEN_W'(1);
			current_q       <= current_q - tgsa_pkg::CUR_W'(1);
		end
	end

	assign result.green_north = green_q[0];
	assign result.green_east  = green_q[1];
	assign result.green_south = green_q[2];
	assign result.green_west  = green_q[3];

endmodule
`default_nettype wire

### tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// address slot past the last register, writes there must be dropped
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES  = 700;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_ITEMS  = 125;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	tgsa_pkg::in_item_t   in_data  = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	tgsa_pkg::out_item_t  out_data;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [tgsa_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]          pwdata  = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// shadow copy of the registers and the splits still owed by the block
	tgsa_pkg::cfg_t      shadow_cfg;
	tgsa_pkg::out_item_t pending_splits[$];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	int tx_gap_pct     = 0;
	int rx_stall_pct   = 0;
	int hold_off_req   = 0;

	traffic_green_split_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// expected green split for one request under the shadow registers
	function automatic tgsa_pkg::out_item_t predict_split(input tgsa_pkg::in_item_t req);
		logic [31:0] dens [tgsa_pkg::NUM_DIRS];
		logic [31:0] grn [tgsa_pkg::NUM_DIRS];
		logic [31:0] sum, floor_total, budget, spare, total, lo, hi, target;
		int          i, pick;
		bit          found;
		tgsa_pkg::out_item_t res;
		lo = 32'(shadow_cfg.grn_floor);
		hi = 32'(shadow_cfg.grn_cap);
		target = 32'(shadow_cfg.cyc_target);
		dens[0] = 32'(req.dens_north);
		dens[1] = 32'(req.dens_east);
		dens[2] = 32'(req.dens_south);
		dens[3] = 32'(req.dens_west);
		sum = '0;
		total = '0;
		for (i = 0; i < tgsa_pkg::NUM_DIRS; i++) begin
			sum += dens[i];
			grn[i] = lo;
		end
		if (sum != 0) begin
			floor_total = lo * tgsa_pkg::NUM_DIRS;
			budget = (target > floor_total) ? target : floor_total;
			spare = budget - floor_total;
			// proportional share, halves rounded up, capped
			for (i = 0; i < tgsa_pkg::NUM_DIRS; i++) begin
				grn[i] = lo + (32'd2 * dens[i] * spare + sum) / (32'd2 * sum);
				if (grn[i] > hi)
					grn[i] = hi;
				total += grn[i];
			end
			// top up the densest direction still below the cap
			while (total < budget) begin
				found = 1'b0;
				pick = 0;
				for (i = 0; i < tgsa_pkg::NUM_DIRS; i++)
					if (grn[i] < hi && (!found || dens[i] > dens[pick])) begin
						pick = i;
						found = 1'b1;
					end
				if (!found)
					break;
				grn[pick]++;
				total++;
			end
			// trim the sparsest direction still above the floor
			while (total > budget) begin
				found = 1'b0;
				pick = 0;
				for (i = 0; i < tgsa_pkg::NUM_DIRS; i++)
					if (grn[i] > lo && (!found || dens[i] < dens[pick])) begin
						pick = i;
						found = 1'b1;
					end
				if (!found)
					break;
				grn[pick]--;
				total--;
			end
		end
		res.green_north = grn[0][tgsa_pkg::GREEN_W-1:0];
		res.green_east  = grn[1][tgsa_pkg::GREEN_W-1:0];
		res.green_south = grn[2][tgsa_pkg::GREEN_W-1:0];
		res.green_west  = grn[3][tgsa_pkg::GREEN_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// idle lengths: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 15);
		return $urandom_range(40, 150);
	endfunction

	// offer one request and record its expected split once taken
	task automatic send_request(input tgsa_pkg::in_item_t req);
		int gap;
		gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_splits.push_back(predict_split(req));
	endtask

	// stop offering and wait for every owed split
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_splits.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			tgsa_pkg::REG_CYC_TARGET:
				shadow_cfg.cyc_target = value[tgsa_pkg::GREEN_W-1:0];
			tgsa_pkg::REG_GRN_FLOOR:
				shadow_cfg.grn_floor  = value[tgsa_pkg::MIN_W-1:0];
			tgsa_pkg::REG_GRN_CAP:
				shadow_cfg.grn_cap    = value[tgsa_pkg::GREEN_W-1:0];
			default: ;
		endcase
	endtask

	// upper bits carry junk that the block must mask off
	task automatic set_config(input int cb, input int mg, input int mx);
		write_reg(tgsa_pkg::REG_CYC_TARGET, cb | ($urandom & 32'hFFFF_FF00));
		write_reg(tgsa_pkg::REG_GRN_FLOOR, mg | ($urandom & 32'hFFFF_FFC0));
		write_reg(tgsa_pkg::REG_GRN_CAP, mx | ($urandom & 32'hFFFF_FF00));
	endtask

	// random densities in a handful of traffic shapes
	function automatic tgsa_pkg::in_item_t rand_densities();
		tgsa_pkg::in_item_t req;
		tgsa_pkg::dens_t    f, level;
		int                 mode, hot, i;
		mode = $urandom_range(0, 11);
		hot = $urandom_range(0, tgsa_pkg::NUM_DIRS - 1);
		level = tgsa_pkg::dens_t'($urandom);
		for (i = 0; i < tgsa_pkg::NUM_DIRS; i++) begin
			case (mode)
				0: f = '0;
				1: f = tgsa_pkg::dens_t'($urandom_range(0, 3));
				2: f = (i == hot) ? tgsa_pkg::dens_t'($urandom) : '0;
				3: f = level;
				4: f = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				5: f = $urandom_range(0, 1) ? 16'h0000 : tgsa_pkg::dens_t'($urandom);
				6: f = tgsa_pkg::dens_t'($urandom_range(0, 255));
				default: f = tgsa_pkg::dens_t'($urandom);
			endcase
			req[i*tgsa_pkg::DENS_W +: tgsa_pkg::DENS_W] = f;
		end
		return req;
	endfunction

	task automatic pick_random_config();
		int kind, cb, mg, mx;
		kind = $urandom_range(0, 9);
		cb = $urandom_range(0, 255);
		mg = $urandom_range(0, 63);
		mx = $urandom_range(0, 255);
		case (kind)
			0: begin
				cb = int'(tgsa_pkg::CYC_TARGET_RST);
				mg = int'(tgsa_pkg::GRN_FLOOR_RST);
				mx = int'(tgsa_pkg::GRN_CAP_RST);
			end
			1: begin
				cb = 255;
				mg = 63;
				mx = 255;
			end
			2: begin
				cb = 0;
				mg = 0;
				mx = 0;
			end
			// fully random, floor may sit above the cap
			3: ;
			// low caps can leave the budget out of reach
			4: mx = $urandom_range(0, 70);
			default: if (mx < mg) mx = $urandom_range(mg, 255);
		endcase
		set_config(cb, mg, mx);
	endtask

	// directed requests under the reset register values
	task automatic test_reset_defaults();
		tx_gap_pct = 30;
		rx_stall_pct = 30;
		send_request({16'h0000, 16'h0000, 16'h0000, 16'h0000});
		send_request({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_request({16'h0001, 16'h0000, 16'h0000, 16'h0000});
		send_request({16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
		send_request({16'h0001, 16'h0001, 16'h0001, 16'h0001});
		send_request({16'h0001, 16'h0002, 16'h0003, 16'h0004});
		send_request({16'hFFFF, 16'h0001, 16'h0000, 16'h0000});
		send_request({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
		send_request({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
		wait_drained();
	endtask

	// register extremes, floor above cap, unreachable budget, spare address
	task automatic test_register_extremes();
		set_config(255, 0, 255);
		send_request({16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
		send_request({16'h0001, 16'h0001, 16'h0001, 16'h0001});
		wait_drained();
		set_config(255, 63, 255);
		send_request({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_request({16'h0000, 16'h0000, 16'h0000, 16'h0001});
		wait_drained();
		set_config(255, 0, 10);
		send_request({16'h0001, 16'h0000, 16'h0000, 16'h0000});
		wait_drained();
		set_config(0, 0, 0);
		send_request({16'h0000, 16'h0000, 16'h0000, 16'h0000});
		send_request({16'hFFFF, 16'h0001, 16'h0002, 16'h0003});
		wait_drained();
		set_config(100, 40, 20);
		send_request({16'h0005, 16'h0000, 16'h0009, 16'h0000});
		send_request({16'h0000, 16'h0000, 16'h0000, 16'h0000});
		wait_drained();
		set_config(0, 10, 60);
		send_request({16'h0003, 16'h0003, 16'h0000, 16'h0007});
		wait_drained();
		write_reg(REG_SPARE, $urandom);
		send_request({16'h0002, 16'h0004, 16'h0006, 16'h0008});
		wait_drained();
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_output_backpressure();
		int i;
		set_config(int'(tgsa_pkg::CYC_TARGET_RST), int'(tgsa_pkg::GRN_FLOOR_RST),
			int'(tgsa_pkg::GRN_CAP_RST));
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		hold_off_req = HOLD_CYCLES;
		for (i = 0; i < 10; i++)
			send_request(rand_densities());
		wait_drained();
	endtask

	// random traffic over a series of register settings
	task automatic test_random_traffic();
		int phase, i;
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			pick_random_config();
			if (phase % 3 == 0) begin
				tx_gap_pct = 0;
				rx_stall_pct = 0;
			end else begin
				tx_gap_pct = $urandom_range(10, 60);
				rx_stall_pct = $urandom_range(10, 60);
			end
			for (i = 0; i < PHASE_ITEMS; i++)
				send_request(rand_densities());
			wait_drained();
		end
	endtask

	// receiver side: random stalls plus requested hold-offs
	initial begin : rx_side
		int n;
		forever begin
			@(posedge clk);
			n = 0;
			if (hold_off_req > 0) begin
				n = hold_off_req;
				hold_off_req = 0;
			end else if ($urandom_range(0, 99) < rx_stall_pct) begin
				n = pick_gap();
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each taken split with the oldest one owed
	always @(posedge clk) begin : split_check
		tgsa_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_splits.size() == 0) begin
				report_mismatch("split with none owed, green_north", out_data.green_north, -1);
			end else begin
				want = pending_splits.pop_front();
				if (out_data.green_north !== want.green_north)
					report_mismatch("green_north", out_data.green_north, want.green_north);
				if (out_data.green_east !== want.green_east)
					report_mismatch("green_east", out_data.green_east, want.green_east);
				if (out_data.green_south !== want.green_south)
					report_mismatch("green_south", out_data.green_south, want.green_south);
				if (out_data.green_west !== want.green_west)
					report_mismatch("green_west", out_data.green_west, want.green_west);
			end
		end
	end

	// watchdog on cycles with no request moving on either side
	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL traffic_green_split_allocator");
		$finish;
	end

	// test sequence
	initial begin : main
		shadow_cfg.cyc_target = tgsa_pkg::CYC_TARGET_RST;
		shadow_cfg.grn_floor  = tgsa_pkg::GRN_FLOOR_RST;
		shadow_cfg.grn_cap    = tgsa_pkg::GRN_CAP_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_output_backpressure();
		test_random_traffic();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS traffic_green_split_allocator");
		else
			$display("FAIL traffic_green_split_allocator");
		$finish;
	end

endmodule

### sim.f
sv/tgsa_pkg.sv
sv/tgsa_ctrl.sv
sv/tgsa_dp.sv
sv/traffic_green_split_allocator.sv
tb/sv/tb.sv
